// ===== rtl/tcpck_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcpck_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned SumW   = 16;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned HdrW   = 6;

  localparam logic [3:0]      MinIhl        = 4'd5;
  localparam logic [IdxW-1:0] IdxLenHi      = 16'd2;
  localparam logic [IdxW-1:0] IdxLenLo      = 16'd3;
  localparam logic [IdxW-1:0] IdxProto      = 16'd9;
  localparam logic [IdxW-1:0] IdxAddrFirst  = 16'd12;
  localparam logic [IdxW-1:0] IdxAddrLast   = 16'd19;

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] data;
    logic             sop;
  } item_t;

  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] checksum;
    logic            length_error;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/tcpck_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcpck_in_stage (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  [tcpck_pkg::DataW-1:0] data_byte_i,
  input  wire                         start_of_packet_i,
  input  wire                         advance_i,
  output tcpck_pkg::item_t            item_o
);
  import tcpck_pkg::*;

  logic             valid_q;
  logic [DataW-1:0] data_q;
  logic             sop_q;

  assign in_stall_o = valid_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= data_byte_i;
      sop_q  <= start_of_packet_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;
  assign item_o.sop   = sop_q;

endmodule

`default_nettype wire

// ===== rtl/tcpck_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcpck_engine (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire tcpck_pkg::item_t  item_i,
  input  wire                    advance_i,
  output tcpck_pkg::res_t        res_o
);
  import tcpck_pkg::*;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  tl_q, tl_d;
  logic [HdrW-1:0]  hb_q, hb_d;
  logic [SumW-1:0]  acc_q, acc_d;
  logic [DataW-1:0] hold_q, hold_d;
  logic             done_q, done_d;

  logic [IdxW-1:0]  idx_e, tl_e;
  logic [HdrW-1:0]  hb_e;
  logic [SumW-1:0]  acc_e;
  logic [DataW-1:0] hold_e;
  logic             done_e;

  logic             fire;
  logic [DataW-1:0] b;
  logic [3:0]       ihl;
  logic [IdxW-1:0]  hb_wide;
  logic             len_err;
  logic             last_byte;
  logic             add_en;
  logic [SumW-1:0]  addend;
  logic [SumW:0]    sum_raw;
  logic [SumW-1:0]  acc_new;
  logic [SumW-1:0]  word;

  assign fire = item_i.valid && advance_i;
  assign b    = item_i.data;

  // start of packet clears the running state before the byte is taken
  assign idx_e  = item_i.sop ? '0 : idx_q;
  assign tl_e   = item_i.sop ? '0 : tl_q;
  assign hb_e   = item_i.sop ? '0 : hb_q;
  assign acc_e  = item_i.sop ? '0 : acc_q;
  assign hold_e = item_i.sop ? '0 : hold_q;
  assign done_e = item_i.sop ? 1'b0 : done_q;

  assign word = {hold_e, b};

  always_comb begin
    ihl = b[3:0];
    if (ihl < MinIhl) begin
      ihl = MinIhl;
    end
  end

  always_comb begin
    hb_d = hb_e;
    tl_d = tl_e;
    if (idx_e == '0) begin
      hb_d = {ihl, 2'b00};
    end
    if (idx_e == IdxLenHi) begin
      tl_d = {b, 8'h00};
    end else if (idx_e == IdxLenLo) begin
      tl_d = {tl_e[15:8], b};
    end
  end

  assign hb_wide   = {{(IdxW-HdrW){1'b0}}, hb_d};
  assign len_err   = (idx_e == IdxLenLo) && (tl_d < hb_wide);
  assign last_byte = (idx_e >= IdxAddrLast) &&
                     (({1'b0, idx_e} + 17'd1) == {1'b0, tl_d});

  always_comb begin
    add_en = 1'b0;
    addend = '0;
    priority if (idx_e == IdxLenLo) begin
      add_en = 1'b1;
      addend = tl_d - hb_wide;
    end else if (idx_e == IdxProto) begin
      add_en = 1'b1;
      addend = {8'h00, b};
    end else if (idx_e[0] && idx_e >= IdxAddrFirst && idx_e <= IdxAddrLast) begin
      add_en = 1'b1;
      addend = word;
    end else if (idx_e >= hb_wide && idx_e < tl_d) begin
      if (idx_e[0]) begin
        add_en = 1'b1;
        addend = word;
      end else if (({1'b0, idx_e} + 17'd1) == {1'b0, tl_d}) begin
        add_en = 1'b1;
        addend = {b, 8'h00};
      end
    end else begin
      add_en = 1'b0;
    end
  end

  // ones-complement add with end-around carry
  assign sum_raw = {1'b0, acc_e} + {1'b0, addend};
  assign acc_new = sum_raw[SumW-1:0] + {{(SumW-1){1'b0}}, sum_raw[SumW]};

  always_comb begin
    idx_d  = idx_e;
    acc_d  = acc_e;
    hold_d = hold_e;
    done_d = done_e;
    res_o  = '0;
    if (!done_e) begin
      if (len_err) begin
        done_d             = 1'b1;
        res_o.valid        = 1'b1;
        res_o.length_error = 1'b1;
      end else begin
        if (add_en) begin
          acc_d = acc_new;
        end
        if (!idx_e[0]) begin
          hold_d = b;
        end
        if (last_byte) begin
          done_d         = 1'b1;
          res_o.valid    = 1'b1;
          res_o.checksum = ~acc_d;
        end else begin
          idx_d = idx_e + 16'd1;
        end
      end
    end
    if (!fire) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      tl_q   <= '0;
      hb_q   <= '0;
      acc_q  <= '0;
      hold_q <= '0;
      done_q <= 1'b1;
    end else if (fire) begin
      idx_q  <= idx_d;
      tl_q   <= tl_d;
      hb_q   <= hb_d;
      acc_q  <= acc_d;
      hold_q <= hold_d;
      done_q <= done_d;
    end
  end

  a_res_needs_fire : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> fire)
    else $error("result without a processed byte");

  a_err_zero_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.length_error) |-> (res_o.checksum == '0))
    else $error("length error with nonzero checksum");

  a_done_after_res : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> done_q)
    else $error("packet still active after its result");

endmodule

`default_nettype wire

// ===== rtl/tcpck_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcpck_out_stage (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire tcpck_pkg::res_t       res_i,
  output logic                       advance_o,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [tcpck_pkg::SumW-1:0] checksum_o,
  output logic                       length_error_o
);
  import tcpck_pkg::*;

  logic            valid_q;
  logic [SumW-1:0] checksum_q;
  logic            err_q;

  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.valid) begin
      checksum_q <= res_i.checksum;
      err_q      <= res_i.length_error;
    end
  end

  assign out_valid_o    = valid_q;
  assign checksum_o     = checksum_q;
  assign length_error_o = err_q;

endmodule

`default_nettype wire

// ===== rtl/tcp_ipv4_checksum_top.sv =====
// TCP checksum over an IPv4 packet streamed one byte per transaction, first header byte
// marked by start_of_packet. The header length, total length, protocol and addresses are
// picked from the header to form the pseudo-header; segment bytes are summed as big-endian
// words with a zero-padded odd tail. One transaction leaves per packet, on its last byte
// (index total length minus one): the inverted ones-complement sum, or length_error with a
// zero checksum when the total length is below the header length (reported on byte 3).
// Bytes outside a packet are dropped, and a new start_of_packet abandons the current one.
// Throughput is one byte per cycle while out_stall does not hold the output, set by the single
// 16-bit end-around-carry adder that updates the running sum in the stage between the input and
// result registers; the result is registered in the output stage when its last byte is taken.
`timescale 1ns / 1ps
`default_nettype none

module tcp_ipv4_checksum_top (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  [tcpck_pkg::DataW-1:0] data_byte_i,
  input  wire                         start_of_packet_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [tcpck_pkg::SumW-1:0]  checksum_o,
  output logic                        length_error_o
);
  import tcpck_pkg::*;

  item_t item;
  res_t  res;
  logic  advance;

  tcpck_in_stage u_in_stage (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .start_of_packet_i (start_of_packet_i),
    .advance_i         (advance),
    .item_o            (item)
  );

  tcpck_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .advance_i (advance),
    .res_o     (res)
  );

  tcpck_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_i          (res),
    .advance_o      (advance),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .checksum_o     (checksum_o),
    .length_error_o (length_error_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_tcp_ipv4_checksum_top.sv =====
`timescale 1ns / 1ps

module tb_tcp_ipv4_checksum_top;
  import tcpck_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             sop;
    logic             has_exp;
    logic [SumW-1:0]  exp_sum;
    logic             exp_err;
  } byte_row_t;

  typedef struct packed {
    logic [SumW-1:0] checksum;
    logic            length_error;
  } cksum_res_t;

  typedef enum int unsigned {RxFlow, RxLight, RxHeavy, RxBeat} rx_mode_e;

  localparam int unsigned DirRows   = 32;
  localparam int unsigned RandBytes = 1300;

  // directed bytes; expected result typed in only for length errors
  localparam byte_row_t DirTab [DirRows] = '{
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},  // no packet active after reset
    '{8'h4F, 1'b1, 1'b0, 16'h0000, 1'b0},  // 60-byte header
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h3B, 1'b0, 1'b1, 16'h0000, 1'b1},  // total 59 below header
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},  // ignored after result
    '{8'h45, 1'b1, 1'b0, 16'h0000, 1'b0},  // dropped by restart
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h40, 1'b1, 1'b0, 16'h0000, 1'b0},  // ihl 0 taken as 20 bytes
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h13, 1'b0, 1'b1, 16'h0000, 1'b1},  // total 19 below 20
    '{8'h45, 1'b1, 1'b0, 16'h0000, 1'b0},  // minimal packet, empty segment
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h14, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0}
  };

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [DataW-1:0] data_byte    = '0;
  logic             sop          = 1'b0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [SumW-1:0]  checksum;
  logic             length_error;

  byte_row_t   stim_q [$];
  cksum_res_t  cksum_q [$];
  byte_row_t   cur_row;
  int unsigned next_idx   = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned errors     = 0;
  int unsigned cyc_rx     = 0;
  int unsigned hold_left  = 0;
  rx_mode_e    rx_mode    = RxFlow;

  // predictor state
  logic [IdxW-1:0] pk_idx;
  logic [15:0]     pk_total;
  logic [HdrW-1:0] pk_hdr;
  logic [31:0]     pk_sum;
  logic [7:0]      pk_hold;
  logic            pk_idle = 1'b1;

  tcp_ipv4_checksum_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .data_byte_i       (data_byte),
    .start_of_packet_i (sop),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .checksum_o        (checksum),
    .length_error_o    (length_error)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic checksum_byte(input logic [7:0] b, input logic s, output bit got,
                               output cksum_res_t res);
    int unsigned i;
    logic [3:0]  ihl;
    logic [31:0] folded;
    got = 1'b0;
    res = '0;
    if (s) begin
      pk_idx   = '0;
      pk_total = '0;
      pk_hdr   = '0;
      pk_sum   = '0;
      pk_hold  = '0;
      pk_idle  = 1'b0;
    end
    if (pk_idle) return;
    i = pk_idx;
    if (i == 0) begin
      ihl = b[3:0];
      if (ihl < MinIhl) ihl = MinIhl;
      pk_hdr = {ihl, 2'b00};
    end else if (i == IdxLenHi) begin
      pk_total = {b, 8'h00};
    end else if (i == IdxLenLo) begin
      pk_total = pk_total | {8'h00, b};
      if (pk_total < pk_hdr) begin
        pk_idle = 1'b1;
        got = 1'b1;
        res.length_error = 1'b1;
        return;
      end
      pk_sum = pk_sum + (32'(pk_total) - 32'(pk_hdr));
    end else if (i == IdxProto) begin
      pk_sum = pk_sum + 32'(b);
    end
    if (!i[0]) pk_hold = b;
    else if (i >= IdxAddrFirst && i <= IdxAddrLast) pk_sum = pk_sum + 32'({pk_hold, b});
    // segment words, odd tail padded low
    if (i >= pk_hdr && i < pk_total) begin
      if (i[0]) pk_sum = pk_sum + 32'({pk_hold, b});
      else if (i + 1 == pk_total) pk_sum = pk_sum + 32'({b, 8'h00});
    end
    if (i >= IdxAddrLast && i + 1 == pk_total) begin
      folded = {16'h0000, pk_sum[15:0]} + {16'h0000, pk_sum[31:16]};
      folded = {16'h0000, folded[15:0]} + {16'h0000, folded[31:16]};
      pk_idle = 1'b1;
      got = 1'b1;
      res.checksum = ~folded[15:0];
      return;
    end
    pk_idx = IdxW'(i + 1);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic s);
    byte_row_t r;
    r = '0;
    r.data = b;
    r.sop = s;
    stim_q.push_back(r);
  endtask

  task automatic add_packet(input int unsigned pkt_no);
    int unsigned kind, ihl, hb, tl, nbytes;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    ihl  = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
    hb   = ((ihl < 5) ? 5 : ihl) * 4;
    if (kind < 10) begin
      // length error, maybe with trailing bytes
      tl = $urandom_range(0, hb - 1);
      nbytes = 4 + $urandom_range(0, 2);
    end else if (kind < 18) begin
      // any total length, cut short by the next start
      tl = $urandom_range(0, 65535);
      nbytes = $urandom_range(1, 48);
    end else begin
      tl = hb + ((pkt_no == 6) ? $urandom_range(300, 600) : $urandom_range(0, 41));
      nbytes = tl + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
    end
    for (int unsigned k = 0; k < nbytes; k++) begin
      case (k)
        0: b = {(($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h4), 4'(ihl)};
        2: b = 8'(tl >> 8);
        3: b = 8'(tl);
        default: b = 8'($urandom);
      endcase
      add_byte(b, k == 0);
    end
    if ($urandom_range(0, 9) == 0) add_byte(8'($urandom), 1'b0);
  endtask

  always @(posedge clk_i) begin : drive
    bit         take, got;
    cksum_res_t res;
    take = in_valid && !in_stall;
    if (take) begin
      checksum_byte(cur_row.data, cur_row.sop, got, res);
      if (cur_row.has_exp) cksum_q.push_back({cur_row.exp_sum, cur_row.exp_err});
      else if (got) cksum_q.push_back(res);
    end
    if (!rst_ni || (in_valid && !take)) begin
      // hold the stalled transaction
    end else if (gap_left != 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (next_idx < stim_q.size()) begin
      cur_row = stim_q[next_idx];
      next_idx++;
      in_valid  <= 1'b1;
      data_byte <= cur_row.data;
      sop       <= cur_row.sop;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : rx_stall
    bit nxt;
    cyc_rx++;
    if (cyc_rx % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    // long hold-off so the block backs up into its input
    if (cyc_rx == 1000 || cyc_rx == 2500) hold_left = 500;
    if (hold_left != 0) begin
      hold_left--;
      nxt = 1'b1;
    end else begin
      case (rx_mode)
        RxFlow:  nxt = 1'b0;
        RxLight: nxt = ($urandom_range(0, 3) == 0);
        RxHeavy: nxt = ($urandom_range(0, 3) != 0);
        default: nxt = cyc_rx[3];
      endcase
    end
    out_stall <= rst_ni ? nxt : 1'b0;
  end

  always @(posedge clk_i) begin : check
    cksum_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (cksum_q.size() == 0) begin
        $display("%0t: unexpected result checksum %h length_error %b",
                 $time, checksum, length_error);
        errors++;
      end else begin
        want = cksum_q.pop_front();
        if (checksum !== want.checksum) begin
          $display("%0t: checksum expected %h actual %h", $time, want.checksum, checksum);
          errors++;
        end
        if (length_error !== want.length_error) begin
          $display("%0t: length_error expected %b actual %b",
                   $time, want.length_error, length_error);
          errors++;
        end
      end
    end
  end

  initial begin : main
    int unsigned pkt_no;
    pkt_no = 0;
    for (int unsigned r = 0; r < DirRows; r++) stim_q.push_back(DirTab[r]);
    while (stim_q.size() < DirRows + RandBytes) begin
      add_packet(pkt_no);
      pkt_no++;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (next_idx < stim_q.size() || in_valid) @(posedge clk_i);
    while (cksum_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_tcp_ipv4_checksum_top: PASS");
    end else begin
      $display("tb_tcp_ipv4_checksum_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_tcp_ipv4_checksum_top: FAIL");
    $finish;
  end

endmodule
